[rtl/ddo_pkg.sv]
// ---------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and tables for the differential drive odometry.
// ---------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int ADDR_W = 2;

  localparam logic [ADDR_W-1:0] REG_CM_PER_TICK    = 2'd0;
  localparam logic [ADDR_W-1:0] REG_INV_WHEEL_BASE = 2'd1;
  localparam logic [ADDR_W-1:0] REG_IMU_WEIGHT     = 2'd2;

  localparam logic [31:0] CM_PER_TICK_RST    = 32'd517466;
  localparam logic [31:0] INV_WHEEL_BASE_RST = 32'd464320790;
  localparam logic [16:0] IMU_WEIGHT_RST     = 17'd0;
  localparam logic [16:0] W_ONE              = 17'd65536;

  localparam logic [25:0] PI_Q24        = 26'd52707179;
  localparam logic [26:0] TWO_PI_Q24    = 27'd105414357;
  localparam logic [26:0] HALF_PI_Q24   = 27'd26353589;
  localparam logic [26:0] HALF_PI_X2    = 27'd52707178;
  localparam logic [26:0] HALF_PI_X3    = 27'd79060767;
  localparam logic [32:0] RED_BIAS      = 33'd2213701497;
  localparam logic [15:0] IMU_FULL      = 16'd46080;
  localparam logic [27:0] IMU_RAD_K     = 28'd149922641;
  localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;
  localparam logic signed [47:0] DIFF_LIM = 48'sh4000_0000_0000;

  localparam logic [3:0] TERM_LAST_SIN  = 4'd4;
  localparam logic [3:0] TERM_FIRST_COS = 4'd5;
  localparam logic [3:0] TERM_LAST_COS  = 4'd10;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RED, ST_QUAD, ST_MDL, ST_MDR, ST_MX2, ST_X2,
    ST_HM, ST_HA, ST_HR, ST_HC, ST_HF, ST_SF, ST_SFR,
    ST_XH, ST_XL, ST_YH, ST_YL, ST_TH, ST_TL, ST_IM, ST_UW,
    ST_BL, ST_BF, ST_DONE
  } ddo_state_t;

  typedef struct packed {
    logic [31:0] cm_per_tick;
    logic [31:0] inv_wheel_base;
    logic [16:0] imu_weight;
  } ddo_cfg_t;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [15:0]        imu_angle;
  } ddo_smp_t;

  typedef struct packed {
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] heading;
  } ddo_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ddo_stat_t;

  // Taylor term divisors: sine terms first, then cosine terms
  function automatic logic [7:0] term_div(input logic [3:0] i);
    logic [7:0] k;
    unique case (i)
      4'd0:    k = 8'd110;
      4'd1:    k = 8'd72;
      4'd2:    k = 8'd42;
      4'd3:    k = 8'd20;
      4'd4:    k = 8'd6;
      4'd5:    k = 8'd132;
      4'd6:    k = 8'd90;
      4'd7:    k = 8'd56;
      4'd8:    k = 8'd30;
      4'd9:    k = 8'd12;
      4'd10:   k = 8'd2;
      default: k = 8'd1;
    endcase
    return k;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] term_recip(input logic [3:0] i);
    logic [31:0] r;
    unique case (i)
      4'd0:    r = 32'd39045157;
      4'd1:    r = 32'd59652323;
      4'd2:    r = 32'd102261126;
      4'd3:    r = 32'd214748364;
      4'd4:    r = 32'd715827882;
      4'd5:    r = 32'd32537631;
      4'd6:    r = 32'd47721858;
      4'd7:    r = 32'd76695844;
      4'd8:    r = 32'd143165576;
      4'd9:    r = 32'd357913941;
      4'd10:   r = 32'd2147483648;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ddo_if.sv]
// ---------------------------------------------------------------------------
// ddo_if
// Valid/ready channels of the odometry block: sample, result, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface ddo_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic [15:0]        imu_angle;
  modport source (output valid, left_count, right_count, imu_angle, input ready);
  modport sink   (input valid, left_count, right_count, imu_angle, output ready);
endinterface

interface ddo_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic signed [31:0] heading;
  modport source (output valid, x_pos, y_pos, heading, input ready);
  modport sink   (input valid, x_pos, y_pos, heading, output ready);
endinterface

interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[rtl/differential_drive_odometry.sv]
// ---------------------------------------------------------------------------
// differential_drive_odometry
// Wheel encoder and IMU odometry: position in cm, blended heading in rad.
// ---------------------------------------------------------------------------
//  channel  dir  word
//  sample   in   left_count, right_count, imu_angle
//  result   out  x_pos, y_pos, heading
//  cfg      in   addr, data (cm_per_tick, inv_wheel_base, imu_weight)
//
//  sample.ready rises on the same edge that loads the result. The
//  sequencer time-shares the single 33x33 multiplier; each Taylor
//  term steps through the states HM, HA, HR, HC and HF.
//  Synchronous reset clears the pose, turn count and previous counts.
//  A held result stalls the sequencer in its last step only.
// ---------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry (
  input  logic          clk,
  input  logic          rst,
  ddo_sample_if.sink    sample,
  ddo_result_if.source  result,
  ddo_cfg_if.sink       cfg
);

  ddo_pkg::ddo_cfg_t  cfg_q;
  ddo_pkg::ddo_smp_t  smp;
  ddo_pkg::ddo_res_t  res;
  ddo_pkg::ddo_stat_t stat;
  logic               out_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.cm_per_tick    <= ddo_pkg::CM_PER_TICK_RST;
      cfg_q.inv_wheel_base <= ddo_pkg::INV_WHEEL_BASE_RST;
      cfg_q.imu_weight     <= ddo_pkg::IMU_WEIGHT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        ddo_pkg::REG_CM_PER_TICK:    cfg_q.cm_per_tick    <= cfg.data;
        ddo_pkg::REG_INV_WHEEL_BASE: cfg_q.inv_wheel_base <= cfg.data;
        ddo_pkg::REG_IMU_WEIGHT:     cfg_q.imu_weight     <= cfg.data[16:0];
        default: ;
      endcase
    end
  end

  assign smp.left_count  = sample.left_count;
  assign smp.right_count = sample.right_count;
  assign smp.imu_angle   = sample.imu_angle;
  assign sample.ready    = stat.idle;

  ddo_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (sample.valid && sample.ready),
    .hold  (out_valid),
    .smp   (smp),
    .cfg   (cfg_q),
    .res   (res),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      result.x_pos   <= res.x_pos;
      result.y_pos   <= res.y_pos;
      result.heading <= res.heading;
    end
  end

  assign result.valid = out_valid;

`ifndef SYNTHESIS
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample accepted while busy");
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !out_valid)
    else $error("result overwritten before taken");
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.done))
    else $error("result valid without finished sample");
`endif

endmodule

`default_nettype wire

[rtl/ddo_mul.sv]
// ---------------------------------------------------------------------------
// ddo_mul
// Shared signed 33x33 multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= 66'(a) * 66'(b);
  end

endmodule

`default_nettype wire

[rtl/ddo_seq.sv]
// ---------------------------------------------------------------------------
// ddo_seq
// Sequencer and datapath: angle reduction, sine/cosine series, position
// and heading update; all products go through one shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 hold,
  input  ddo_pkg::ddo_smp_t    smp,
  input  ddo_pkg::ddo_cfg_t    cfg,
  output ddo_pkg::ddo_res_t    res,
  output ddo_pkg::ddo_stat_t   stat
);

  localparam logic [26:0] TWO_PI_EXT = ddo_pkg::TWO_PI_Q24;

  ddo_pkg::ddo_state_t state, state_next;

  logic signed [31:0] pos_x, pos_y, ang, prev_l, prev_r;
  logic signed [15:0] turns;
  logic signed [43:0] ovf;

  logic signed [31:0] del_l, del_r;
  logic [15:0]        imu;
  logic [32:0]        red;
  logic [2:0]         red_k;
  logic [1:0]         quad;
  logic [30:0]        x;
  logic [31:0]        x2;
  logic signed [32:0] t, sf, s_v, c_v;
  logic [3:0]         idx;
  logic               neg;
  logic [31:0]        av, q0;
  logic signed [47:0] dl, dr, mean, diff;
  logic signed [65:0] acc;
  logic signed [31:0] enc, imu_term;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p;

  logic [32:0]        red_step;
  logic [26:0]        r_mod, r_off;
  logic [1:0]         q_sel;
  logic [31:0]        rem, qq;
  logic [7:0]         kdiv;
  logic signed [32:0] qs, t_new;
  logic signed [48:0] sum49, dif49;
  logic signed [47:0] diff_c;
  logic signed [45:0] imu_rad, err, ovf_w;
  logic signed [43:0] ovf_next;
  logic signed [15:0] turns_next;
  logic signed [17:0] imu_off;
  logic [16:0]        w_eff;

  ddo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  always_comb begin
    red_step = 33'(TWO_PI_EXT) << red_k;
    r_mod    = red[26:0];
    if (r_mod >= ddo_pkg::HALF_PI_X3) begin
      q_sel = 2'd3;
      r_off = ddo_pkg::HALF_PI_X3;
    end else if (r_mod >= ddo_pkg::HALF_PI_X2) begin
      q_sel = 2'd2;
      r_off = ddo_pkg::HALF_PI_X2;
    end else if (r_mod >= ddo_pkg::HALF_PI_Q24) begin
      q_sel = 2'd1;
      r_off = ddo_pkg::HALF_PI_Q24;
    end else begin
      q_sel = 2'd0;
      r_off = 27'd0;
    end

    kdiv  = ddo_pkg::term_div(idx);
    rem   = av - p[31:0];
    qq    = (rem >= {24'd0, kdiv}) ? q0 + 32'd1 : q0;
    qs    = $signed({1'b0, qq});
    t_new = ddo_pkg::ONE_Q30 - (neg ? -qs : qs);

    sum49  = 49'(dl) + 49'(dr);
    dif49  = 49'(dr) - 49'(dl);
    if (dif49 > 49'(ddo_pkg::DIFF_LIM)) begin
      diff_c = ddo_pkg::DIFF_LIM;
    end else if (dif49 < -49'(ddo_pkg::DIFF_LIM)) begin
      diff_c = -ddo_pkg::DIFF_LIM;
    end else begin
      diff_c = 48'(dif49);
    end

    imu_off = $signed({2'b00, ddo_pkg::IMU_FULL}) - $signed({2'b00, imu});
    imu_rad = 46'(p >>> 16);
    err     = 46'(ang) - (imu_rad + 46'(ovf));
    turns_next = turns;
    ovf_next   = ovf;
    if (err > $signed({20'd0, ddo_pkg::PI_Q24}) ||
        err < -$signed({20'd0, ddo_pkg::PI_Q24})) begin
      if (err > 46'sd0) begin
        if (turns != 16'sh7fff) begin
          turns_next = turns + 16'sd1;
          ovf_next   = ovf + $signed({17'd0, ddo_pkg::TWO_PI_Q24});
        end
      end else begin
        if (turns != 16'sh8000) begin
          turns_next = turns - 16'sd1;
          ovf_next   = ovf - $signed({17'd0, ddo_pkg::TWO_PI_Q24});
        end
      end
    end
    ovf_w = 46'(ovf_next);

    w_eff = (cfg.imu_weight > ddo_pkg::W_ONE) ? ddo_pkg::W_ONE : cfg.imu_weight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::ST_IDLE: if (start) state_next = ddo_pkg::ST_RED;
      ddo_pkg::ST_RED:  if (red_k == 3'd0) state_next = ddo_pkg::ST_QUAD;
      ddo_pkg::ST_QUAD: state_next = ddo_pkg::ST_MDL;
      ddo_pkg::ST_MDL:  state_next = ddo_pkg::ST_MDR;
      ddo_pkg::ST_MDR:  state_next = ddo_pkg::ST_MX2;
      ddo_pkg::ST_MX2:  state_next = ddo_pkg::ST_X2;
      ddo_pkg::ST_X2:   state_next = ddo_pkg::ST_HM;
      ddo_pkg::ST_HM:   state_next = ddo_pkg::ST_HA;
      ddo_pkg::ST_HA:   state_next = ddo_pkg::ST_HR;
      ddo_pkg::ST_HR:   state_next = ddo_pkg::ST_HC;
      ddo_pkg::ST_HC:   state_next = ddo_pkg::ST_HF;
      ddo_pkg::ST_HF: begin
        if (idx == ddo_pkg::TERM_LAST_COS) begin
          state_next = ddo_pkg::ST_XH;
        end else if (idx == ddo_pkg::TERM_LAST_SIN) begin
          state_next = ddo_pkg::ST_SF;
        end else begin
          state_next = ddo_pkg::ST_HM;
        end
      end
      ddo_pkg::ST_SF:   state_next = ddo_pkg::ST_SFR;
      ddo_pkg::ST_SFR:  state_next = ddo_pkg::ST_HM;
      ddo_pkg::ST_XH:   state_next = ddo_pkg::ST_XL;
      ddo_pkg::ST_XL:   state_next = ddo_pkg::ST_YH;
      ddo_pkg::ST_YH:   state_next = ddo_pkg::ST_YL;
      ddo_pkg::ST_YL:   state_next = ddo_pkg::ST_TH;
      ddo_pkg::ST_TH:   state_next = ddo_pkg::ST_TL;
      ddo_pkg::ST_TL:   state_next = ddo_pkg::ST_IM;
      ddo_pkg::ST_IM:   state_next = ddo_pkg::ST_UW;
      ddo_pkg::ST_UW:   state_next = ddo_pkg::ST_BL;
      ddo_pkg::ST_BL:   state_next = ddo_pkg::ST_BF;
      ddo_pkg::ST_BF:   state_next = ddo_pkg::ST_DONE;
      ddo_pkg::ST_DONE: if (!hold) state_next = ddo_pkg::ST_IDLE;
      default:          state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    stat.idle = 1'b0;
    stat.done = 1'b0;
    unique case (state)
      ddo_pkg::ST_IDLE: stat.idle = 1'b1;
      ddo_pkg::ST_MDL: begin
        mul_a = 33'(del_l);
        mul_b = $signed({1'b0, cfg.cm_per_tick});
      end
      ddo_pkg::ST_MDR: begin
        mul_a = 33'(del_r);
        mul_b = $signed({1'b0, cfg.cm_per_tick});
      end
      ddo_pkg::ST_MX2: begin
        mul_a = $signed({2'b00, x});
        mul_b = $signed({2'b00, x});
      end
      ddo_pkg::ST_HM: begin
        mul_a = $signed({1'b0, x2});
        mul_b = t;
      end
      ddo_pkg::ST_HR: begin
        mul_a = $signed({1'b0, av});
        mul_b = $signed({1'b0, ddo_pkg::term_recip(idx)});
      end
      ddo_pkg::ST_HC: begin
        mul_a = $signed({1'b0, p[63:32]});
        mul_b = $signed({25'd0, kdiv});
      end
      ddo_pkg::ST_SF: begin
        mul_a = $signed({2'b00, x});
        mul_b = t;
      end
      ddo_pkg::ST_XH: begin
        mul_a = 33'(mean >>> 16);
        mul_b = s_v;
      end
      ddo_pkg::ST_XL: begin
        mul_a = $signed({17'd0, mean[15:0]});
        mul_b = s_v;
      end
      ddo_pkg::ST_YH: begin
        mul_a = 33'(mean >>> 16);
        mul_b = c_v;
      end
      ddo_pkg::ST_YL: begin
        mul_a = $signed({17'd0, mean[15:0]});
        mul_b = c_v;
      end
      ddo_pkg::ST_TH: begin
        mul_a = 33'(diff >>> 16);
        mul_b = $signed({1'b0, cfg.inv_wheel_base});
      end
      ddo_pkg::ST_TL: begin
        mul_a = $signed({17'd0, diff[15:0]});
        mul_b = $signed({1'b0, cfg.inv_wheel_base});
      end
      ddo_pkg::ST_IM: begin
        mul_a = 33'(imu_off);
        mul_b = $signed({5'd0, ddo_pkg::IMU_RAD_K});
      end
      ddo_pkg::ST_UW: begin
        mul_a = $signed({16'd0, ddo_pkg::W_ONE - w_eff});
        mul_b = 33'(enc);
      end
      ddo_pkg::ST_BL: begin
        mul_a = $signed({16'd0, w_eff});
        mul_b = 33'(imu_term);
      end
      ddo_pkg::ST_DONE: stat.done = !hold;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x  <= '0;
      pos_y  <= '0;
      ang    <= '0;
      turns  <= '0;
      ovf    <= '0;
      prev_l <= '0;
      prev_r <= '0;
      red_k  <= '0;
      idx    <= '0;
    end else begin
      unique case (state)
        ddo_pkg::ST_IDLE: begin
          if (start) begin
            prev_l <= smp.left_count;
            prev_r <= smp.right_count;
            red_k  <= 3'd5;
          end
        end
        ddo_pkg::ST_RED: red_k <= red_k - 3'd1;
        ddo_pkg::ST_X2:  idx <= '0;
        ddo_pkg::ST_HF:  if (idx != ddo_pkg::TERM_LAST_COS) idx <= idx + 4'd1;
        ddo_pkg::ST_SFR: idx <= ddo_pkg::TERM_FIRST_COS;
        ddo_pkg::ST_YH:
          pos_x <= ddo_pkg::sat32(66'(pos_x) - (acc + (p >>> 30)));
        ddo_pkg::ST_TH:
          pos_y <= ddo_pkg::sat32(66'(pos_y) + acc + (p >>> 30));
        ddo_pkg::ST_UW: begin
          turns <= turns_next;
          ovf   <= ovf_next;
        end
        ddo_pkg::ST_BF:  ang <= ddo_pkg::sat32((acc + p) >>> 16);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ddo_pkg::ST_IDLE: begin
        del_l <= smp.left_count - prev_l;
        del_r <= smp.right_count - prev_r;
        imu   <= smp.imu_angle;
        red   <= {ang[31], ang} + ddo_pkg::RED_BIAS;
      end
      ddo_pkg::ST_RED: if (red >= red_step) red <= red - red_step;
      ddo_pkg::ST_QUAD: begin
        quad <= q_sel;
        x    <= {r_mod[24:0] - r_off[24:0], 6'd0};
      end
      ddo_pkg::ST_MDR: dl <= 48'(p >>> 16);
      ddo_pkg::ST_MX2: dr <= 48'(p >>> 16);
      ddo_pkg::ST_X2: begin
        x2   <= p[61:30];
        mean <= 48'(sum49 >>> 1);
        diff <= diff_c;
        t    <= ddo_pkg::ONE_Q30;
      end
      ddo_pkg::ST_HA: begin
        neg <= p[65];
        av  <= p[65] ? 32'(-(p >>> 30)) : 32'(p >>> 30);
      end
      ddo_pkg::ST_HC: q0 <= p[63:32];
      ddo_pkg::ST_HF: begin
        t <= t_new;
        if (idx == ddo_pkg::TERM_LAST_COS) begin
          unique case (quad)
            2'd0: begin s_v <= sf;     c_v <= t_new;  end
            2'd1: begin s_v <= t_new;  c_v <= -sf;    end
            2'd2: begin s_v <= -sf;    c_v <= -t_new; end
            2'd3: begin s_v <= -t_new; c_v <= sf;     end
            default: ;
          endcase
        end
      end
      ddo_pkg::ST_SFR: begin
        sf <= 33'(p >>> 30);
        t  <= ddo_pkg::ONE_Q30;
      end
      ddo_pkg::ST_XL: acc <= p >>> 14;
      ddo_pkg::ST_YL: acc <= p >>> 14;
      ddo_pkg::ST_TL: acc <= p >>> 8;
      ddo_pkg::ST_IM: enc <= ddo_pkg::sat32(66'(ang) + acc + (p >>> 24));
      ddo_pkg::ST_UW: imu_term <= ddo_pkg::sat32(66'(imu_rad + ovf_w));
      ddo_pkg::ST_BL: acc <= p;
      default: ;
    endcase
  end

  assign res.x_pos   = pos_x;
  assign res.y_pos   = pos_y;
  assign res.heading = ang;

endmodule

`default_nettype wire
